// ===== hdl/bqd_pkg.sv =====
// Shared constants for the biquad IIR filter: coefficient format and register indexes.
package bqd_pkg;

	localparam int COEF_BITS    = 24;
	localparam int COEF_FRAC    = 20;
	localparam int CFG_IDX_BITS = 3;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_B0 = cfg_idx_t'(0);
	localparam cfg_idx_t REG_B1 = cfg_idx_t'(1);
	localparam cfg_idx_t REG_B2 = cfg_idx_t'(2);
	localparam cfg_idx_t REG_A1 = cfg_idx_t'(3);
	localparam cfg_idx_t REG_A2 = cfg_idx_t'(4);

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// Unity gain in Q4.20.
	localparam coef_t B0_RESET = coef_t'(1) <<< COEF_FRAC;

endpackage

// ===== hdl/biquad_iir_filter.sv =====
// Top level of the multi-channel direct form I biquad IIR filter.
// Each accepted request carries one signed sample and a channel number; the filter returns
// b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 for that channel, rounded half up from Q4.20
// coefficient scaling and saturated to the sample range. A request is captured in an input
// register; the five products and their sum are then formed and land in the result register
// once that register is free, and a new request can be taken every cycle while the output
// is not stalled. The per-channel history is updated as the item leaves the input register,
// so consecutive samples of the same channel need no gap. Coefficients must be written through
// the cfg port only while the filter is idle; the block itself does not enforce this.
module biquad_iir_filter
	import bqd_pkg::*;
#(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  cfg_idx_t                      cfg_index,
	input  logic [COEF_BITS-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          chan,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          chan_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W    = PROD_W + 3;
	localparam int TOP_W    = ACC_W - COEF_FRAC - SAMPLE_BITS + 1;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	coef_t b0_q, b1_q, b2_q, a1_q, a2_q;

	logic signed [SAMPLE_BITS-1:0] xh1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] xh2_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] yh1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] yh2_q [CHANNELS];

	logic                          valid_s1;
	logic                          chan_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;

	logic                          out_adv;
	logic                          fire_s1;
	logic [CH_IDX_W-1:0]           ch_idx;
	logic signed [PROD_W-1:0]      p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]       acc;
	logic signed [ACC_W-1:0]       rnd;
	logic [TOP_W-1:0]              rnd_top;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// The result register frees up when it is empty or being read this cycle.
	assign out_adv  = !out_valid || out_ready;
	assign fire_s1  = valid_s1 && out_adv;
	assign in_ready = !valid_s1 || out_adv;

	assign ch_idx = (CHANNELS > 1) ? CH_IDX_W'(chan_s1) : '0;

	always_comb begin
		p_b0 = x_s1 * b0_q;
		p_b1 = xh1_q[ch_idx] * b1_q;
		p_b2 = xh2_q[ch_idx] * b2_q;
		p_a1 = yh1_q[ch_idx] * a1_q;
		p_a2 = yh2_q[ch_idx] * a2_q;
		acc  = p_b0 + p_b1 + p_b2 - p_a1 - p_a2;
		rnd  = acc + ROUND_HALF;
		rnd_top = rnd[ACC_W-1:COEF_FRAC+SAMPLE_BITS-1];
		// The rounded value fits when all bits above the sample's sign bit match it.
		if (rnd_top == '0 || rnd_top == '1) begin
			y_sat = rnd[COEF_FRAC+SAMPLE_BITS-1:COEF_FRAC];
		end else if (rnd_top[TOP_W-1]) begin
			y_sat = SAMPLE_MIN;
		end else begin
			y_sat = SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= B0_RESET;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0: b0_q <= cfg_data;
				REG_B1: b1_q <= cfg_data;
				REG_B2: b2_q <= cfg_data;
				REG_A1: a1_q <= cfg_data;
				REG_A2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chan_s1 <= chan;
			x_s1    <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				xh1_q[c] <= '0;
				xh2_q[c] <= '0;
				yh1_q[c] <= '0;
				yh2_q[c] <= '0;
			end
		end else if (fire_s1) begin
			xh2_q[ch_idx] <= xh1_q[ch_idx];
			xh1_q[ch_idx] <= x_s1;
			yh2_q[ch_idx] <= yh1_q[ch_idx];
			yh1_q[ch_idx] <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			chan_out   <= chan_s1;
			sample_out <= y_sat;
		end
	end

endmodule

// ===== hdl/bqd_checker.sv =====
// Port-level checker for the biquad IIR filter, bound to the top level.
module bqd_checker
	import bqd_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_we,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   chan_out,
	input logic [SAMPLE_BITS-1:0] sample_out
);

	// A stalled result must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(chan_out))
		else $error("result changed while stalled");

	// Requests are only refused while a finished result waits downstream.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without downstream stall");

	// A result appearing on an empty output comes from a request taken into the input register before it.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching request");

	// Coefficients change only while no result is stalled at the output.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_valid || out_ready)
		else $error("configuration written while a result was stalled");

endmodule

bind biquad_iir_filter bqd_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_bqd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.chan_out   (chan_out),
	.sample_out (sample_out)
);
